// File: src/pslw_pkg.sv
// types, codes and constants shared by the proximity speed limiter watchdog
package pslw_pkg;

  localparam int CMD_W      = 16;
  localparam int DIST_W     = 16;
  localparam int LIM_W      = 15;
  localparam int TICK_W     = 8;
  localparam int ZONE_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int QUO_W      = 15;
  localparam int DVD_W      = DIST_W + QUO_W;

  localparam logic OP_COMMAND = 1'b0;
  localparam logic OP_TICK    = 1'b1;

  localparam logic [ZONE_W-1:0] ZONE_NORMAL   = 2'd0;
  localparam logic [ZONE_W-1:0] ZONE_SLOW     = 2'd1;
  localparam logic [ZONE_W-1:0] ZONE_STOP     = 2'd2;
  localparam logic [ZONE_W-1:0] ZONE_WATCHDOG = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_STOP_DISTANCE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW_DISTANCE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LINEAR    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ANGULAR   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT       = 3'd4;

  localparam logic [DIST_W-1:0] RST_STOP_DISTANCE = 16'd200;
  localparam logic [DIST_W-1:0] RST_SLOW_DISTANCE = 16'd500;
  localparam logic [LIM_W-1:0]  RST_MAX_LINEAR    = 15'd307;
  localparam logic [LIM_W-1:0]  RST_MAX_ANGULAR   = 15'd1024;
  localparam logic [TICK_W-1:0] RST_TIMEOUT       = 8'd5;

  localparam logic [DIST_W-1:0] INVALID_DISTANCE_MM = 16'd10000;
  localparam logic [TICK_W-1:0] TICK_MAX            = 8'd255;

  typedef struct packed {
    logic                    operation;
    logic signed [CMD_W-1:0] linear_cmd;
    logic signed [CMD_W-1:0] angular_cmd;
    logic [DIST_W-1:0]       distance_mm;
    logic                    distance_valid;
  } in_t;

  typedef struct packed {
    logic signed [CMD_W-1:0] linear_out;
    logic signed [CMD_W-1:0] angular_out;
    logic [ZONE_W-1:0]       zone;
  } out_t;

  typedef struct packed {
    logic [DIST_W-1:0] stop_distance_mm;
    logic [DIST_W-1:0] slow_distance_mm;
    logic [LIM_W-1:0]  max_linear_slow;
    logic [LIM_W-1:0]  max_angular_slow;
    logic [TICK_W-1:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic [DVD_W-1:0]  dividend;
    logic [DIST_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [QUO_W-1:0] quotient;
  } div_rsp_t;

endpackage

// File: src/proximity_speed_limiter_watchdog.sv
// proximity speed limiter with command watchdog, top level and sequencer
//
//   channel | signals                        | item
//   --------+--------------------------------+--------------------------------
//   in      | in_valid, in_ready, in_data    | velocity command or watchdog tick
//   out     | out_valid, out_ready, out_data | limited velocities and zone
//   cfg     | cfg_write, cfg_index, cfg_data | one register write, no wait
//
// one item at a time; in_ready is high only while the sequencer is idle.
// a tick that gives no result leaves the sequencer idle; a firing
// tick, stop zone and normal zone items go straight to the done state.
// slow zone items pass a multiply state and the single serial divider, which
// runs 15 steps for each velocity, linear first, angular second, then done.
// a finished result waits in the result registers; the sequencer holds it if the
// previous one has not been taken. synchronous reset clears control, presets config.
module proximity_speed_limiter_watchdog (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  pslw_pkg::in_t                   in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output pslw_pkg::out_t                  out_data,
  input  logic                            cfg_write,
  input  logic [pslw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pslw_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  localparam int CW = pslw_pkg::CMD_W;
  localparam int DW = pslw_pkg::DIST_W;
  localparam int LW = pslw_pkg::LIM_W;
  localparam int TW = pslw_pkg::TICK_W;

  pslw_pkg::cfg_t     cfg;
  pslw_pkg::div_req_t div_req;
  pslw_pkg::div_rsp_t div_rsp;

  logic [1:0]                  state;
  logic                        sel;
  logic signed [CW-1:0]        lin_cmd;
  logic signed [CW-1:0]        ang_cmd;
  logic [DW-1:0]               num;
  logic signed [CW-1:0]        lin_res;
  logic signed [CW-1:0]        ang_res;
  logic [pslw_pkg::ZONE_W-1:0] zone_res;
  logic [TW-1:0]               ticks;
  logic                        stopped;

  logic                        accept;
  logic [DW-1:0]               range_mm;
  logic [TW-1:0]               ticks_next;
  logic                        fire;
  logic signed [CW-1:0]        cur;
  logic                        neg;
  logic [CW-1:0]               mag;
  logic [2*CW-1:0]             prod;
  logic [LW-1:0]               lim;
  logic [LW-1:0]               qc;
  logic [CW-1:0]               res;
  logic                        load_out;

  pslw_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pslw_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_comb begin
    in_ready   = (state == S_IDLE);
    accept     = in_valid && in_ready;
    range_mm   = in_data.distance_valid ? in_data.distance_mm
                                        : pslw_pkg::INVALID_DISTANCE_MM;
    ticks_next = (ticks == pslw_pkg::TICK_MAX) ? ticks : ticks + TW'(1);
    fire       = (ticks_next > cfg.timeout_ticks) && !stopped;

    cur  = sel ? ang_cmd : lin_cmd;
    neg  = cur[CW-1];
    mag  = neg ? (~cur + CW'(1)) : cur;
    prod = {{CW{1'b0}}, mag} * {{(2*CW-DW){1'b0}}, num};

    div_req.start    = (state == S_MUL);
    div_req.dividend = prod[pslw_pkg::DVD_W-1:0];
    div_req.divisor  = cfg.slow_distance_mm - cfg.stop_distance_mm;

    lim = sel ? cfg.max_angular_slow : cfg.max_linear_slow;
    qc  = (div_rsp.quotient > lim) ? lim : div_rsp.quotient;
    res = neg ? (~{1'b0, qc} + CW'(1)) : {1'b0, qc};

    load_out = (state == S_DONE) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sel       <= 1'b0;
      ticks     <= '0;
      stopped   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      priority if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (in_data.operation == pslw_pkg::OP_TICK) begin
              ticks <= ticks_next;
              if (fire) begin
                stopped <= 1'b1;
                state   <= S_DONE;
              end
            end else begin
              ticks   <= '0;
              stopped <= 1'b0;
              sel     <= 1'b0;
              if (range_mm < cfg.stop_distance_mm || range_mm >= cfg.slow_distance_mm) begin
                state <= S_DONE;
              end else begin
                state <= S_MUL;
              end
            end
          end
        end
        S_MUL: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_rsp.done) begin
            sel   <= 1'b1;
            state <= sel ? S_DONE : S_MUL;
          end
        end
        S_DONE: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // item payload and result registers
  always_ff @(posedge clk) begin
    if (accept) begin
      lin_cmd <= in_data.linear_cmd;
      ang_cmd <= in_data.angular_cmd;
      num     <= range_mm - cfg.stop_distance_mm;
      if (in_data.operation == pslw_pkg::OP_TICK) begin
        lin_res  <= '0;
        ang_res  <= '0;
        zone_res <= pslw_pkg::ZONE_WATCHDOG;
      end else if (range_mm < cfg.stop_distance_mm) begin
        lin_res  <= '0;
        ang_res  <= '0;
        zone_res <= pslw_pkg::ZONE_STOP;
      end else if (range_mm < cfg.slow_distance_mm) begin
        zone_res <= pslw_pkg::ZONE_SLOW;
      end else begin
        lin_res  <= in_data.linear_cmd;
        ang_res  <= in_data.angular_cmd;
        zone_res <= pslw_pkg::ZONE_NORMAL;
      end
    end else if (state == S_DIV && div_rsp.done) begin
      if (sel) begin
        ang_res <= res;
      end else begin
        lin_res <= res;
      end
    end
    if (load_out) begin
      out_data.linear_out  <= lin_res;
      out_data.angular_out <= ang_res;
      out_data.zone        <= zone_res;
    end
  end

  // stop and watchdog results never carry motion
  a_stop_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.zone == pslw_pkg::ZONE_STOP ||
                  out_data.zone == pslw_pkg::ZONE_WATCHDOG)
    |-> out_data.linear_out == '0 && out_data.angular_out == '0)
    else $error("stop result with nonzero velocity");

  // slow zone results respect the configured limits
  a_slow_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.zone == pslw_pkg::ZONE_SLOW
    |-> $signed(out_data.linear_out) <= $signed({1'b0, cfg.max_linear_slow}) &&
        $signed(out_data.linear_out) >= -$signed({1'b0, cfg.max_linear_slow}) &&
        $signed(out_data.angular_out) <= $signed({1'b0, cfg.max_angular_slow}) &&
        $signed(out_data.angular_out) >= -$signed({1'b0, cfg.max_angular_slow}))
    else $error("slow zone result exceeds limit");

  // the divider only finishes while the sequencer waits for it
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> state == S_DIV)
    else $error("divider finished outside of divide state");

  // starting the divider makes it busy on the next cycle
  a_div_start: assert property (@(posedge clk) disable iff (rst)
    state == S_MUL |=> div_rsp.busy && state == S_DIV)
    else $error("divider did not start");

endmodule

// File: src/pslw_regs.sv
// configuration register file of the speed limiter
module pslw_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [pslw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pslw_pkg::CFG_DATA_W-1:0]    cfg_data,
  output pslw_pkg::cfg_t                     cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.stop_distance_mm <= pslw_pkg::RST_STOP_DISTANCE;
      cfg.slow_distance_mm <= pslw_pkg::RST_SLOW_DISTANCE;
      cfg.max_linear_slow  <= pslw_pkg::RST_MAX_LINEAR;
      cfg.max_angular_slow <= pslw_pkg::RST_MAX_ANGULAR;
      cfg.timeout_ticks    <= pslw_pkg::RST_TIMEOUT;
    end else if (cfg_write) begin
      unique case (cfg_index)
        pslw_pkg::REG_STOP_DISTANCE: begin
          cfg.stop_distance_mm <= cfg_data[pslw_pkg::DIST_W-1:0];
        end
        pslw_pkg::REG_SLOW_DISTANCE: begin
          cfg.slow_distance_mm <= cfg_data[pslw_pkg::DIST_W-1:0];
        end
        pslw_pkg::REG_MAX_LINEAR: begin
          cfg.max_linear_slow <= cfg_data[pslw_pkg::LIM_W-1:0];
        end
        pslw_pkg::REG_MAX_ANGULAR: begin
          cfg.max_angular_slow <= cfg_data[pslw_pkg::LIM_W-1:0];
        end
        pslw_pkg::REG_TIMEOUT: begin
          cfg.timeout_ticks <= cfg_data[pslw_pkg::TICK_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// File: src/pslw_div.sv
// serial restoring divider, one quotient bit per cycle, quotient known to fit QUO_W bits
module pslw_div (
  input  logic               clk,
  input  logic               rst,
  input  pslw_pkg::div_req_t req,
  output pslw_pkg::div_rsp_t rsp
);

  localparam int CNT_W = $clog2(pslw_pkg::QUO_W);

  logic [pslw_pkg::DIST_W-1:0] rem;
  logic [pslw_pkg::DIST_W-1:0] rem_next;
  logic [pslw_pkg::DIST_W-1:0] den;
  logic [pslw_pkg::QUO_W-1:0]  low;
  logic [pslw_pkg::QUO_W-1:0]  quo;
  logic [CNT_W-1:0]            cnt;
  logic                        busy;
  logic                        done;
  logic [pslw_pkg::DIST_W:0]   trial;
  logic [pslw_pkg::DIST_W:0]   diff;
  logic                        ge;

  always_comb begin
    trial = {rem, low[pslw_pkg::QUO_W-1]};
    diff  = trial - {1'b0, den};
    ge    = trial >= {1'b0, den};
    // remainder stays below the divisor, so it fits back in DIST_W bits
    rem_next = ge ? diff[pslw_pkg::DIST_W-1:0] : trial[pslw_pkg::DIST_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !req.start && busy && (cnt == CNT_W'(pslw_pkg::QUO_W - 1));
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(pslw_pkg::QUO_W - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      // top part is below the divisor since the quotient fits QUO_W bits
      rem <= req.dividend[pslw_pkg::DVD_W-1:pslw_pkg::QUO_W];
      low <= req.dividend[pslw_pkg::QUO_W-1:0];
      den <= req.divisor;
      quo <= '0;
    end else if (busy) begin
      rem <= rem_next;
      low <= {low[pslw_pkg::QUO_W-2:0], 1'b0};
      quo <= {quo[pslw_pkg::QUO_W-2:0], ge};
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule
